/* src/blit_pkg.sv */
`default_nettype none

package blit_pkg;

   // glyph box size in pixels; glyph rows sit eight bits apart in the packed word
   localparam int GLYPH_WIDTH  = 8;
   localparam int GLYPH_HEIGHT = 8;

   // coordinate limit: exclusive clip edges saturate here
   localparam logic signed [14:0] COORD_LIMIT = 15'sd8192;

   // reset value of the clip size registers
   localparam logic [12:0] CLIP_SIZE_RESET = 13'd4096;

   // command codes on the request word
   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_GLYPH = 2'd1,
      OP_STEP  = 2'd2
   } op_type;

   // register indexes on the csr port
   typedef enum logic [1:0] {
      REG_CLIP_LEFT   = 2'd0,
      REG_CLIP_TOP    = 2'd1,
      REG_CLIP_WIDTH  = 2'd2,
      REG_CLIP_HEIGHT = 2'd3
   } reg_index_type;

endpackage

`default_nettype wire

/* src/clipped_fill_and_glyph_blitter.sv */
// Clipped rectangle fill and glyph blitter.
// Request channel (req_*, valid/stall): a fill start (rectangle origin and size plus
// color) or a glyph start (box origin, 64 packed glyph bits, fg and bg colors) sets up
// a span clipped against the clip rectangle and produces no word. Each step word then
// yields one pixel write on the response channel (rsp_*), in row-major order, with
// rsp_last on the final pixel. Steps while no command is running are dropped. A new
// start replaces a running command at once.
// An accepted step's pixel is registered onto rsp_*. Throughput: one word per cycle
// unless stalled; besides the clip registers, the only storage is the command state
// and a single response register, so the span counters advance once per accepted step.
// Stall: req_stall is raised only while the response register is full and the
// receiver stalls it; the pixel then holds until taken.
// Reset (synchronous, active high): no command running, response empty, clip
// rectangle back to origin 0,0 and size 4096 by 4096.
// Clip registers are written over the csr port at byte addresses 0, 4, 8, 12 (left,
// top, width, height); the user writes them only while the block is idle (unenforced).
`default_nettype none

module clipped_fill_and_glyph_blitter (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_stall,
   input  wire         [1:0]  req_op,
   input  wire  signed [12:0] req_origin_x,
   input  wire  signed [12:0] req_origin_y,
   input  wire         [12:0] req_rect_width,
   input  wire         [12:0] req_rect_height,
   input  wire         [63:0] req_glyph_bits,
   input  wire         [7:0]  req_fg_color,
   input  wire         [7:0]  req_bg_color,
   // response channel
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic        [12:0] rsp_pixel_x,
   output logic        [12:0] rsp_pixel_y,
   output logic        [7:0]  rsp_pixel_color,
   output logic               rsp_last,
   // csr port
   input  wire                csr_psel,
   input  wire                csr_penable,
   input  wire                csr_pwrite,
   input  wire         [3:0]  csr_paddr,
   input  wire         [31:0] csr_pwdata,
   output logic        [31:0] csr_prdata,
   output logic               csr_pready
);

   // clip registers
   logic [11:0] clip_left_ff,   clip_left_in;
   logic [11:0] clip_top_ff,    clip_top_in;
   logic [12:0] clip_width_ff,  clip_width_in;
   logic [12:0] clip_height_ff, clip_height_in;

   // command state
   logic               active_ff,      active_in;
   logic               is_glyph_ff,    is_glyph_in;
   logic        [12:0] cur_col_ff,     cur_col_in;
   logic        [12:0] cur_row_ff,     cur_row_in;
   logic        [12:0] span_left_ff,   span_left_in;
   logic        [13:0] span_right_ff,  span_right_in;
   logic        [13:0] span_bottom_ff, span_bottom_in;
   logic signed [12:0] box_left_ff,    box_left_in;
   logic signed [12:0] box_top_ff,     box_top_in;
   logic        [63:0] held_glyph_ff,  held_glyph_in;
   logic        [7:0]  held_fg_ff,     held_fg_in;
   logic        [7:0]  held_bg_ff,     held_bg_in;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] rsp_x_ff,     rsp_x_in;
   logic [12:0] rsp_y_ff,     rsp_y_in;
   logic [7:0]  rsp_color_ff, rsp_color_in;
   logic        rsp_last_ff,  rsp_last_in;

   logic req_accept;
   logic csr_write;
   logic [1:0] csr_index;

   // clip intersection signals
   logic signed [14:0] org_x, org_y, ext_w, ext_h, end_x, end_y;
   logic signed [14:0] clip_l, clip_t, clip_r, clip_b;
   logic        [13:0] clip_r_raw, clip_b_raw;
   logic signed [14:0] x0, y0, x1, y1;
   logic               span_empty;

   // step signals
   logic [13:0] col_next, row_next;
   logic [12:0] row_off, col_off;
   logic        glyph_bit;
   logic [7:0]  step_color;

   // handshakes
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3:2];

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last        = rsp_last_ff;

   // csr read mux
   always_comb begin
      csr_prdata = '0;
      unique case (blit_pkg::reg_index_type'(csr_index))
         blit_pkg::REG_CLIP_LEFT:   csr_prdata = {20'd0, clip_left_ff};
         blit_pkg::REG_CLIP_TOP:    csr_prdata = {20'd0, clip_top_ff};
         blit_pkg::REG_CLIP_WIDTH:  csr_prdata = {19'd0, clip_width_ff};
         blit_pkg::REG_CLIP_HEIGHT: csr_prdata = {19'd0, clip_height_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // csr writes
   always_comb begin
      clip_left_in   = clip_left_ff;
      clip_top_in    = clip_top_ff;
      clip_width_in  = clip_width_ff;
      clip_height_in = clip_height_ff;
      if (csr_write) begin
         unique case (blit_pkg::reg_index_type'(csr_index))
            blit_pkg::REG_CLIP_LEFT:   clip_left_in   = csr_pwdata[11:0];
            blit_pkg::REG_CLIP_TOP:    clip_top_in    = csr_pwdata[11:0];
            blit_pkg::REG_CLIP_WIDTH:  clip_width_in  = csr_pwdata[12:0];
            blit_pkg::REG_CLIP_HEIGHT: clip_height_in = csr_pwdata[12:0];
            default: ;
         endcase
      end
   end

   // box extent for the start word
   always_comb begin
      org_x = {{2{req_origin_x[12]}}, req_origin_x};
      org_y = {{2{req_origin_y[12]}}, req_origin_y};
      if (req_op == blit_pkg::OP_FILL) begin
         ext_w = {2'b00, req_rect_width};
         ext_h = {2'b00, req_rect_height};
      end else begin
         ext_w = 15'(blit_pkg::GLYPH_WIDTH);
         ext_h = 15'(blit_pkg::GLYPH_HEIGHT);
      end
      end_x = org_x + ext_w;
      end_y = org_y + ext_h;
   end

   // clip edges, exclusive right and bottom saturate at the coordinate limit
   always_comb begin
      clip_l     = {3'b000, clip_left_ff};
      clip_t     = {3'b000, clip_top_ff};
      clip_r_raw = {2'b00, clip_left_ff} + {1'b0, clip_width_ff};
      clip_b_raw = {2'b00, clip_top_ff} + {1'b0, clip_height_ff};
      clip_r     = ({1'b0, clip_r_raw} > blit_pkg::COORD_LIMIT) ?
                   blit_pkg::COORD_LIMIT : {1'b0, clip_r_raw};
      clip_b     = ({1'b0, clip_b_raw} > blit_pkg::COORD_LIMIT) ?
                   blit_pkg::COORD_LIMIT : {1'b0, clip_b_raw};
   end

   // intersection of box and clip
   always_comb begin
      x0 = (org_x > clip_l) ? org_x : clip_l;
      y0 = (org_y > clip_t) ? org_y : clip_t;
      x1 = (end_x < clip_r) ? end_x : clip_r;
      y1 = (end_y < clip_b) ? end_y : clip_b;
      span_empty = (x0 >= x1) || (y0 >= y1);
   end

   // current pixel color and span advance
   always_comb begin
      row_off    = cur_row_ff - box_top_ff;
      col_off    = cur_col_ff - box_left_ff;
      glyph_bit  = held_glyph_ff[{row_off[2:0], col_off[2:0]}];
      step_color = (is_glyph_ff && !glyph_bit) ? held_bg_ff : held_fg_ff;
      col_next   = {1'b0, cur_col_ff} + 14'd1;
      row_next   = {1'b0, cur_row_ff} + 14'd1;
   end

   // next state
   always_comb begin
      active_in      = active_ff;
      is_glyph_in    = is_glyph_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      span_left_in   = span_left_ff;
      span_right_in  = span_right_ff;
      span_bottom_in = span_bottom_ff;
      box_left_in    = box_left_ff;
      box_top_in     = box_top_ff;
      held_glyph_in  = held_glyph_ff;
      held_fg_in     = held_fg_ff;
      held_bg_in     = held_bg_ff;

      // response register drains when taken
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_last_in  = rsp_last_ff;

      if (req_accept) begin
         unique case (req_op) inside
            blit_pkg::OP_FILL, blit_pkg::OP_GLYPH: begin
               is_glyph_in   = (req_op == blit_pkg::OP_GLYPH);
               held_glyph_in = req_glyph_bits;
               held_fg_in    = req_fg_color;
               held_bg_in    = req_bg_color;
               box_left_in   = req_origin_x;
               box_top_in    = req_origin_y;
               active_in     = ~span_empty;
               if (!span_empty) begin
                  span_left_in   = x0[12:0];
                  span_right_in  = x1[13:0];
                  span_bottom_in = y1[13:0];
                  cur_col_in     = x0[12:0];
                  cur_row_in     = y0[12:0];
               end
            end
            blit_pkg::OP_STEP: begin
               if (active_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = cur_col_ff;
                  rsp_y_in     = cur_row_ff;
                  rsp_color_in = step_color;
                  rsp_last_in  = 1'b0;
                  if (col_next < span_right_ff) begin
                     cur_col_in = col_next[12:0];
                  end else if (row_next < span_bottom_ff) begin
                     cur_col_in = span_left_ff;
                     cur_row_in = row_next[12:0];
                  end else begin
                     rsp_last_in = 1'b1;
                     active_in   = 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= blit_pkg::CLIP_SIZE_RESET;
         clip_height_ff <= blit_pkg::CLIP_SIZE_RESET;
         active_ff      <= 1'b0;
         is_glyph_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         clip_left_ff   <= clip_left_in;
         clip_top_ff    <= clip_top_in;
         clip_width_ff  <= clip_width_in;
         clip_height_ff <= clip_height_in;
         active_ff      <= active_in;
         is_glyph_ff    <= is_glyph_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cur_col_ff     <= cur_col_in;
      cur_row_ff     <= cur_row_in;
      span_left_ff   <= span_left_in;
      span_right_ff  <= span_right_in;
      span_bottom_ff <= span_bottom_in;
      box_left_ff    <= box_left_in;
      box_top_ff     <= box_top_in;
      held_glyph_ff  <= held_glyph_in;
      held_fg_ff     <= held_fg_in;
      held_bg_ff     <= held_bg_in;
      rsp_x_ff       <= rsp_x_in;
      rsp_y_ff       <= rsp_y_in;
      rsp_color_ff   <= rsp_color_in;
      rsp_last_ff    <= rsp_last_in;
   end

endmodule

`default_nettype wire

/* bench/clipped_fill_and_glyph_blitter_test.sv */
`default_nettype none

module clipped_fill_and_glyph_blitter_test;
   timeunit 1ns;
   timeprecision 1ps;

   // op code with no command behind it
   localparam logic [1:0] OP_UNUSED = 2'd3;
   // cycles without any accepted word before the run is abandoned
   localparam int STUCK_LIMIT = 2000;
   // cycles the receiver holds off once to back up the block
   localparam int HOLD_CYCLES = 300;
   // counted items per clip setting
   localparam int PHASE_QUOTA = 110;
   localparam int MAX_REPORTS = 50;

   typedef struct {
      logic [1:0]         op;
      logic signed [12:0] origin_x;
      logic signed [12:0] origin_y;
      logic [12:0]        rect_width;
      logic [12:0]        rect_height;
      logic [63:0]        glyph_bits;
      logic [7:0]         fg_color;
      logic [7:0]         bg_color;
   } blit_word_type;

   typedef struct {
      logic [12:0] x;
      logic [12:0] y;
      logic [7:0]  color;
      logic        last;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid       = 1'b0;
   wire                req_stall;
   logic [1:0]         req_op          = '0;
   logic signed [12:0] req_origin_x    = '0;
   logic signed [12:0] req_origin_y    = '0;
   logic [12:0]        req_rect_width  = '0;
   logic [12:0]        req_rect_height = '0;
   logic [63:0]        req_glyph_bits  = '0;
   logic [7:0]         req_fg_color    = '0;
   logic [7:0]         req_bg_color    = '0;

   wire                rsp_valid;
   logic               rsp_stall       = 1'b0;
   wire  [12:0]        rsp_pixel_x;
   wire  [12:0]        rsp_pixel_y;
   wire  [7:0]         rsp_pixel_color;
   wire                rsp_last;

   logic               csr_psel        = 1'b0;
   logic               csr_penable     = 1'b0;
   logic               csr_pwrite      = 1'b0;
   logic [3:0]         csr_paddr       = '0;
   logic [31:0]        csr_pwdata      = '0;
   wire  [31:0]        csr_prdata;
   wire                csr_pready;

   clipped_fill_and_glyph_blitter i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .req_glyph_bits  (req_glyph_bits),
      .req_fg_color    (req_fg_color),
      .req_bg_color    (req_bg_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #5 clock = ~clock;

   // words waiting to be sent and pixels waiting to come back
   blit_word_type pending_words[$];
   pixel_type     pixels_due[$];

   int error_count    = 0;
   int fill_count     = 0;
   int glyph_count    = 0;
   int ignored_count  = 0;
   int replaced_count = 0;
   int pixels_checked = 0;
   int last_count     = 0;
   int setting_count  = 0;

   // clip rectangle as the block should hold it
   logic [11:0] clip_left   = 12'd0;
   logic [11:0] clip_top    = 12'd0;
   logic [12:0] clip_width  = blit_pkg::CLIP_SIZE_RESET;
   logic [12:0] clip_height = blit_pkg::CLIP_SIZE_RESET;

   // running command as the block should hold it
   bit          run_active = 1'b0;
   bit          run_glyph  = 1'b0;
   int          cur_col    = 0;
   int          cur_row    = 0;
   int          span_left  = 0;
   int          span_right = 0;
   int          span_bottom = 0;
   int          box_left   = 0;
   int          box_top    = 0;
   logic [63:0] held_glyph = '0;
   logic [7:0]  held_fg    = '0;
   logic [7:0]  held_bg    = '0;

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // intersection of a box with the clip rectangle, right and bottom exclusive
   function automatic void clip_span(input int x, input int y, input int w, input int h,
                                     output int x0, output int y0,
                                     output int x1, output int y1);
      int cr;
      int cb;
      cr = int'(clip_left) + int'(clip_width);
      cb = int'(clip_top) + int'(clip_height);
      if (cr > int'(blit_pkg::COORD_LIMIT)) cr = int'(blit_pkg::COORD_LIMIT);
      if (cb > int'(blit_pkg::COORD_LIMIT)) cb = int'(blit_pkg::COORD_LIMIT);
      x0 = (x > int'(clip_left)) ? x : int'(clip_left);
      y0 = (y > int'(clip_top)) ? y : int'(clip_top);
      x1 = (x + w < cr) ? x + w : cr;
      y1 = (y + h < cb) ? y + h : cb;
   endfunction

   // number of pixels a start word sets up under the current clip
   function automatic int span_area(input blit_word_type wd);
      int x0, y0, x1, y1;
      if (wd.op == blit_pkg::OP_FILL)
         clip_span(int'(wd.origin_x), int'(wd.origin_y), int'(wd.rect_width),
                   int'(wd.rect_height), x0, y0, x1, y1);
      else
         clip_span(int'(wd.origin_x), int'(wd.origin_y), blit_pkg::GLYPH_WIDTH,
                   blit_pkg::GLYPH_HEIGHT, x0, y0, x1, y1);
      if (x0 >= x1 || y0 >= y1) return 0;
      return (x1 - x0) * (y1 - y0);
   endfunction

   // advance the expected blitter state by one accepted word
   function automatic void blit_accept(input blit_word_type wd);
      int        x0, y0, x1, y1;
      int        r, c;
      pixel_type px;
      if (wd.op == blit_pkg::OP_FILL || wd.op == blit_pkg::OP_GLYPH) begin
         if (run_active) replaced_count++;
         if (wd.op == blit_pkg::OP_FILL) fill_count++;
         else glyph_count++;
         run_glyph  = (wd.op == blit_pkg::OP_GLYPH);
         held_glyph = wd.glyph_bits;
         held_fg    = wd.fg_color;
         held_bg    = wd.bg_color;
         box_left   = int'(wd.origin_x);
         box_top    = int'(wd.origin_y);
         if (run_glyph)
            clip_span(box_left, box_top, blit_pkg::GLYPH_WIDTH, blit_pkg::GLYPH_HEIGHT,
                      x0, y0, x1, y1);
         else
            clip_span(box_left, box_top, int'(wd.rect_width), int'(wd.rect_height),
                      x0, y0, x1, y1);
         if (x0 >= x1 || y0 >= y1) begin
            run_active = 1'b0;
         end else begin
            run_active  = 1'b1;
            span_left   = x0;
            span_right  = x1;
            span_bottom = y1;
            cur_col     = x0;
            cur_row     = y0;
         end
      end else if (wd.op == blit_pkg::OP_STEP && run_active) begin
         px.color = held_fg;
         if (run_glyph) begin
            // glyph rows are eight bits apart
            r = (cur_row - box_top) & 7;
            c = (cur_col - box_left) & 7;
            px.color = held_glyph[r * 8 + c] ? held_fg : held_bg;
         end
         px.x    = cur_col[12:0];
         px.y    = cur_row[12:0];
         px.last = 1'b0;
         if (cur_col + 1 < span_right) begin
            cur_col++;
         end else if (cur_row + 1 < span_bottom) begin
            cur_col = span_left;
            cur_row++;
         end else begin
            px.last    = 1'b1;
            run_active = 1'b0;
         end
         pixels_due.push_back(px);
      end else begin
         ignored_count++;
      end
   endfunction

   // sender: bursts of words with gaps between them
   blit_word_type offered;
   int            burst_left = 1;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = 1;
         gap_left   = 0;
      end else begin
         if (req_valid && !req_stall) blit_accept(offered);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               offered = pending_words.pop_front();
               req_op          <= offered.op;
               req_origin_x    <= offered.origin_x;
               req_origin_y    <= offered.origin_y;
               req_rect_width  <= offered.rect_width;
               req_rect_height <= offered.rect_height;
               req_glyph_bits  <= offered.glyph_bits;
               req_fg_color    <= offered.fg_color;
               req_bg_color    <= offered.bg_color;
               req_valid       <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  case ($urandom_range(0, 9)) inside
                     0:       gap_left = 0;
                     1, 2:    gap_left = $urandom_range(4, 30);
                     default: gap_left = $urandom_range(0, 3);
                  endcase
                  if ($urandom_range(0, 6) == 0) burst_left = $urandom_range(100, 300);
                  else burst_left = $urandom_range(1, 24);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each pixel and stalls on its own pattern
   pixel_type due;
   int        stall_mode = 0;
   int        mode_left  = 0;
   int        hold_left  = 0;
   bit        hold_done  = 1'b0;
   int        cycle_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (rsp_valid && !rsp_stall) begin
            if (pixels_due.size() == 0) begin
               report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                         rsp_pixel_x, rsp_pixel_y));
            end else begin
               due = pixels_due.pop_front();
               pixels_checked++;
               if (due.last) last_count++;
               if (rsp_pixel_x !== due.x)
                  report_mismatch($sformatf("pixel_x got %0d, expected %0d",
                                            rsp_pixel_x, due.x));
               if (rsp_pixel_y !== due.y)
                  report_mismatch($sformatf("pixel_y got %0d, expected %0d",
                                            rsp_pixel_y, due.y));
               if (rsp_pixel_color !== due.color)
                  report_mismatch($sformatf("pixel_color at (%0d,%0d) got %0h, expected %0h",
                                            due.x, due.y, rsp_pixel_color, due.color));
               if (rsp_last !== due.last)
                  report_mismatch($sformatf("last at (%0d,%0d) got %0b, expected %0b",
                                            due.x, due.y, rsp_last, due.last));
            end
         end
         if (hold_left > 0) begin
            // long hold-off so the block backs up into the request channel
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && pixels_checked > 20 && pending_words.size() > 50) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(16, 160);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 1) == 1);
               2:       rsp_stall <= (cycle_count % 4 != 0);
               default: rsp_stall <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // watchdog on cycles with nothing moving
   int stuck_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
            $display("Verification failed");
            $finish;
         end
      end
   end

   // setup and access cycle, register written at the access edge
   task automatic write_clip_reg(input blit_pkg::reg_index_type idx,
                                 input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         blit_pkg::REG_CLIP_LEFT:   clip_left   = value[11:0];
         blit_pkg::REG_CLIP_TOP:    clip_top    = value[11:0];
         blit_pkg::REG_CLIP_WIDTH:  clip_width  = value[12:0];
         blit_pkg::REG_CLIP_HEIGHT: clip_height = value[12:0];
         default: ;
      endcase
   endtask

   task automatic set_clip(input int left, input int top, input int w, input int h);
      write_clip_reg(blit_pkg::REG_CLIP_LEFT, left);
      write_clip_reg(blit_pkg::REG_CLIP_TOP, top);
      write_clip_reg(blit_pkg::REG_CLIP_WIDTH, w);
      write_clip_reg(blit_pkg::REG_CLIP_HEIGHT, h);
      setting_count++;
   endtask

   // wait until every pixel is back and the block has settled
   task automatic wait_drained();
      while (pending_words.size() != 0 || req_valid || pixels_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic blit_word_type make_word(input logic [1:0] op, input int x,
                                               input int y, input int w, input int h,
                                               input logic [63:0] bits,
                                               input logic [7:0] fg, input logic [7:0] bg);
      blit_word_type wd;
      wd.op          = op;
      wd.origin_x    = 13'(x);
      wd.origin_y    = 13'(y);
      wd.rect_width  = 13'(w);
      wd.rect_height = 13'(h);
      wd.glyph_bits  = bits;
      wd.fg_color    = fg;
      wd.bg_color    = bg;
      return wd;
   endfunction

   // word with a random payload on every field but the op code
   function automatic blit_word_type random_word(input logic [1:0] op);
      return make_word(op, $urandom_range(0, 8191), $urandom_range(0, 8191),
                       $urandom_range(0, 4096), $urandom_range(0, 4096),
                       {$urandom, $urandom}, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
   endfunction

   task automatic push_steps(input int n);
      repeat (n) pending_words.push_back(random_word(blit_pkg::OP_STEP));
   endtask

   // coordinate near one edge of a clip range, kept inside the signed field
   function automatic int near_edge(input int lo, input int size);
      int v;
      v = ($urandom_range(0, 1) == 1) ? lo : lo + size;
      v = v + $urandom_range(0, 16) - 10;
      if (v > 4095) v = 4095;
      if (v < -4096) v = -4096;
      return v;
   endfunction

   function automatic int pick_size(input int hi);
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return hi;
         2:       return $urandom_range(1, 16);
         default: return $urandom_range(0, hi);
      endcase
   endfunction

   // mostly complete commands, some cut short, some with stray words
   task automatic queue_random_phase(input int quota);
      int            counted;
      int            area;
      int            steps;
      int            sel;
      blit_word_type wd;
      counted = 0;
      while (counted < quota) begin
         wd = random_word(($urandom_range(0, 1) == 1) ? blit_pkg::OP_GLYPH :
                                                        blit_pkg::OP_FILL);
         if ($urandom_range(0, 7) != 0) begin
            wd.origin_x    = 13'(near_edge(int'(clip_left), int'(clip_width)));
            wd.origin_y    = 13'(near_edge(int'(clip_top), int'(clip_height)));
            wd.rect_width  = 13'(($urandom_range(0, 15) == 0) ? 4096 : $urandom_range(0, 12));
            wd.rect_height = 13'(($urandom_range(0, 15) == 0) ? 4096 : $urandom_range(0, 6));
         end
         area = span_area(wd);
         sel  = $urandom_range(0, 99);
         if (sel < 75) begin
            steps = (area > 64) ? $urandom_range(0, 64) : area;
         end else if (sel < 88) begin
            steps = (area > 0) ? $urandom_range(0, (area > 64) ? 64 : area - 1) : 0;
         end else begin
            steps = (area > 64) ? 64 : area + $urandom_range(1, 3);
         end
         pending_words.push_back(wd);
         if (sel >= 88) pending_words.push_back(random_word(OP_UNUSED));
         push_steps(steps);
         counted += 1 + ((steps < area) ? steps : area);
      end
   endtask

   initial begin
      int left, top, w, h;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      setting_count = 1;

      // directed words under the reset clip
      @(negedge clock);
      push_steps(1);
      pending_words.push_back(make_word(OP_UNUSED, -1, -1, 4096, 4096, '1, 8'hff, 8'hff));
      pending_words.push_back(make_word(blit_pkg::OP_FILL, 4094, 4094, 4096, 4096, '0,
                                        8'hff, 8'h00));
      push_steps(4);
      pending_words.push_back(make_word(blit_pkg::OP_FILL, -4096, -4096, 0, 0, '1,
                                        8'h00, 8'hff));
      push_steps(1);
      pending_words.push_back(make_word(blit_pkg::OP_FILL, -2, -1, 3, 2, '0, 8'h5a, 8'ha5));
      push_steps(2);
      pending_words.push_back(make_word(blit_pkg::OP_GLYPH, 4094, 4094, 0, 0,
                                        64'h0000_0000_0000_0201, 8'hff, 8'h00));
      push_steps(4);
      // fill replaced by a glyph clipped down to its bottom right bit
      pending_words.push_back(make_word(blit_pkg::OP_FILL, 100, 100, 3, 1, '0,
                                        8'h11, 8'h22));
      push_steps(1);
      pending_words.push_back(make_word(blit_pkg::OP_GLYPH, -7, -7, 4096, 4096,
                                        64'h8000_0000_0000_0000, 8'h00, 8'hff));
      push_steps(1);
      pending_words.push_back(make_word(blit_pkg::OP_FILL, 0, 0, 4096, 0, '1,
                                        8'h33, 8'h44));
      push_steps(1);
      @(negedge clock);
      queue_random_phase(PHASE_QUOTA);
      wait_drained();

      // fixed clip settings at the extremes
      for (int i = 0; i < 5; i++) begin
         case (i)
            0: set_clip(4095, 4095, 4096, 4096);
            1: set_clip(0, 0, 0, 4096);
            2: set_clip(0, 0, 4096, 0);
            3: set_clip(7, 3, 1, 1);
            default: set_clip(0, 4095, 4096, 1);
         endcase
         @(negedge clock);
         queue_random_phase(PHASE_QUOTA);
         wait_drained();
      end

      // random clip settings
      for (int i = 0; i < 5; i++) begin
         left = pick_size(4095);
         top  = pick_size(4095);
         w    = pick_size(4096);
         h    = pick_size(4096);
         set_clip(left, top, w, h);
         @(negedge clock);
         queue_random_phase(PHASE_QUOTA);
         wait_drained();
      end

      repeat (8) @(posedge clock);
      if (pixels_due.size() != 0)
         report_mismatch($sformatf("%0d expected pixels never arrived", pixels_due.size()));
      $display("covered %0d fills and %0d glyphs over %0d clip settings, %0d pixels checked",
               fill_count, glyph_count, setting_count, pixels_checked);
      $display("%0d command ends, %0d commands cut off by a new start, %0d words ignored",
               last_count, replaced_count, ignored_count);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
